// ----- rtl/core/mtws_pkg.sv -----
// Package for the masked tricube weighted smoother core.
// Holds sizes, register indexes and input mode codes. No dependencies.
`default_nettype none
package mtws_pkg;
    localparam int MAX_GRID_WIDTH  = 256;
    localparam int MAX_GRID_HEIGHT = 256;
    localparam int MAX_SPAN        = 16;
    localparam int CW  = $clog2(MAX_GRID_WIDTH);
    localparam int RW  = $clog2(MAX_GRID_HEIGHT);
    localparam int SW  = $clog2(MAX_SPAN);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_W = 16 + 15 + CW + RW + 2;
    localparam int DEN_W = 15 + CW + RW + 2;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_WEIGHT = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_VALUE  = 3'd4;

    typedef struct packed {
        logic       start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/mtws_if.sv -----
// Valid/ready channel interfaces for the smoother core.
// Depends on nothing.
`default_nettype none
interface mtws_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [7:0]        col;
    logic [7:0]        row;
    logic signed [15:0] data_value;
    modport source (output valid, mode, col, row, data_value, input ready);
    modport sink   (input valid, mode, col, row, data_value, output ready);
endinterface

interface mtws_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_value;
    logic               all_masked;
    modport source (output valid, filtered_value, all_masked, input ready);
    modport sink   (input valid, filtered_value, all_masked, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtws_divider.sv -----
// Restoring divider: rounded signed quotient of num by den, saturated to 16 bits.
// Depends on mtws_pkg.
`default_nettype none
module mtws_divider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtws_pkg::div_req_t req,
    output logic                 done,
    output logic signed [15:0]   quot
);
    import mtws_pkg::*;
    localparam int DW = NUM_W + 1;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    dvd_reg;
    logic [DW:0]      rem_reg;
    logic [DW:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             neg_reg;
    logic [DW:0]      trial;
    logic [DW:0]      shifted;

    assign shifted = {rem_reg[DW-1:0], dvd_reg[DW-1]};
    assign trial   = shifted - dvs_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
                neg_reg  <= req.num[NUM_W-1];
                // 2*|num| + den, divided by 2*den
                dvd_reg  <= ({1'b0, (req.num[NUM_W-1] ? -req.num : req.num)} << 1)
                            + DW'(req.den);
                dvs_reg  <= (DW+1)'({req.den, 1'b0});
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[DW-2:0], ~trial[DW]};
                rem_reg <= trial[DW] ? shifted : trial;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            quot = (dvd_reg > DW'(32768)) ? 16'sh8000 : 16'(-dvd_reg);
        end else begin
            quot = (dvd_reg > DW'(32767)) ? 16'sh7fff : 16'(dvd_reg);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/masked_tricube_weighted_smoother_core.sv -----
// Masked tricube weighted smoother: sample grid and weight table in memories.
// Sample/weight words are written while idle. A query reads, then accumulates each
// window cell; the sums go to the divider, or the mask value with all_masked set
// is output when all cells are masked. Next word is taken after the result word.
// Reset clears control and sets config registers to defaults; memories are
// undefined until written. Depends on mtws_pkg, mtws_if, mtws_divider.
`default_nettype none
module masked_tricube_weighted_smoother_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mtws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mtws_pkg::CFG_DATA_W-1:0] cfg_data,
    mtws_in_if.sink                           in_ch,
    mtws_out_if.source                        out_ch
);
    import mtws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_ACC, S_DIV, S_WAITDIV, S_OUT
    } state_t;

    logic [8:0]  gw_reg, gh_reg;
    logic [4:0]  sx_reg, sy_reg;
    logic signed [15:0] mask_reg;

    logic [15:0] smem [MAX_GRID_WIDTH*MAX_GRID_HEIGHT];
    logic [14:0] wmem [MAX_SPAN*MAX_SPAN];
    logic [15:0] s_rd_reg;
    logic [14:0] w_rd_reg;

    state_t state_reg;
    logic [CW:0] c0_reg, c1_reg, ci_reg;
    logic [RW:0] r1_reg, rj_reg;
    logic [7:0]  qc_reg, qr_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic     dstart_reg;
    div_req_t dreq;
    logic     ddone;
    logic signed [15:0] dquot;

    logic [8:0] w_c, h_c;
    logic [4:0] sx_c, sy_c;
    logic [CW:0] dx;
    logic [RW:0] dy;
    logic signed [9:0] c0_s, r0_s;
    logic [9:0] c1_s, r1_s;
    logic acc_last_col, acc_last_row;

    always_comb begin
        w_c  = (gw_reg == 9'd0) ? 9'd1 : (gw_reg > 9'(MAX_GRID_WIDTH) ? 9'(MAX_GRID_WIDTH) : gw_reg);
        h_c  = (gh_reg == 9'd0) ? 9'd1 : (gh_reg > 9'(MAX_GRID_HEIGHT) ? 9'(MAX_GRID_HEIGHT) : gh_reg);
        sx_c = (sx_reg == 5'd0) ? 5'd1 : (sx_reg > 5'(MAX_SPAN) ? 5'(MAX_SPAN) : sx_reg);
        sy_c = (sy_reg == 5'd0) ? 5'd1 : (sy_reg > 5'(MAX_SPAN) ? 5'(MAX_SPAN) : sy_reg);
        c0_s = $signed({2'b0, in_ch.col}) - $signed({5'b0, sx_c}) + 10'sd1;
        r0_s = $signed({2'b0, in_ch.row}) - $signed({5'b0, sy_c}) + 10'sd1;
        c1_s = {2'b0, in_ch.col} + {5'b0, sx_c};
        r1_s = {2'b0, in_ch.row} + {5'b0, sy_c};
        dx = (ci_reg > {1'b0, qc_reg}) ? ci_reg - {1'b0, qc_reg} : {1'b0, qc_reg} - ci_reg;
        dy = (rj_reg > {1'b0, qr_reg}) ? rj_reg - {1'b0, qr_reg} : {1'b0, qr_reg} - rj_reg;
        acc_last_col = (ci_reg + 1'b1) >= c1_reg;
        acc_last_row = (rj_reg + 1'b1) >= r1_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gw_reg   <= 9'd256;
            gh_reg   <= 9'd256;
            sx_reg   <= 5'd16;
            sy_reg   <= 5'd16;
            mask_reg <= 16'sh8000;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg   <= cfg_data[8:0];
                REG_GRID_HEIGHT: gh_reg   <= cfg_data[8:0];
                REG_SPAN_X:      sx_reg   <= cfg_data[4:0];
                REG_SPAN_Y:      sy_reg   <= cfg_data[4:0];
                REG_MASK_VALUE:  mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // memory ports
    always_ff @(posedge clk) begin
        if (state_reg == S_IDLE && in_ch.valid && in_ch.mode == MODE_SAMPLE)
            smem[{in_ch.row[RW-1:0], in_ch.col[CW-1:0]}] <= in_ch.data_value;
        if (state_reg == S_IDLE && in_ch.valid && in_ch.mode == MODE_WEIGHT
            && in_ch.col < 8'(MAX_SPAN) && in_ch.row < 8'(MAX_SPAN))
            wmem[{in_ch.row[SW-1:0], in_ch.col[SW-1:0]}] <=
                in_ch.data_value[15] ? 15'd0 : in_ch.data_value[14:0];
        s_rd_reg <= smem[{rj_reg[RW-1:0], ci_reg[CW-1:0]}];
        w_rd_reg <= wmem[{dy[SW-1:0], dx[SW-1:0]}];
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign dreq = '{start: dstart_reg, num: num_reg, den: den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            out_ch.valid <= 1'b0;
            dstart_reg   <= 1'b0;
        end else begin
            dstart_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.mode == MODE_QUERY) begin
                        qc_reg  <= in_ch.col;
                        qr_reg  <= in_ch.row;
                        c0_reg  <= c0_s[9] ? '0 : (CW+1)'(c0_s);
                        ci_reg  <= c0_s[9] ? '0 : (CW+1)'(c0_s);
                        rj_reg  <= r0_s[9] ? '0 : (RW+1)'(r0_s);
                        c1_reg  <= (c1_s > {1'b0, w_c}) ? (CW+1)'(w_c) : (CW+1)'(c1_s);
                        r1_reg  <= (r1_s > {1'b0, h_c}) ? (RW+1)'(h_c) : (RW+1)'(r1_s);
                        num_reg <= '0;
                        den_reg <= '0;
                        // window may be empty when query lies far outside grid
                        if (c0_s >= $signed({1'b0, w_c}) || r0_s >= $signed({1'b0, h_c}))
                            state_reg <= S_DIV;
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_ACC;
                S_ACC: begin
                    if ($signed(s_rd_reg) != mask_reg) begin
                        num_reg <= num_reg + NUM_W'($signed({1'b0, w_rd_reg})
                                   * $signed(s_rd_reg));
                        den_reg <= den_reg + DEN_W'(w_rd_reg);
                    end
                    if (acc_last_col) begin
                        ci_reg <= c0_reg;
                        rj_reg <= rj_reg + 1'b1;
                        state_reg <= acc_last_row ? S_DIV : S_READ;
                    end else begin
                        ci_reg <= ci_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_DIV: begin
                    if (den_reg == '0) begin
                        out_ch.filtered_value <= mask_reg;
                        out_ch.all_masked     <= 1'b1;
                        out_ch.valid          <= 1'b1;
                        state_reg             <= S_OUT;
                    end else begin
                        dstart_reg <= 1'b1;
                        state_reg  <= S_WAITDIV;
                    end
                end
                S_WAITDIV: begin
                    if (ddone) begin
                        out_ch.filtered_value <= dquot;
                        out_ch.all_masked     <= 1'b0;
                        out_ch.valid          <= 1'b1;
                        state_reg             <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        out_ch.valid <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    mtws_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (ddone),
        .quot  (dquot)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == S_OUT) else $error("valid outside output state");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> state_reg == S_WAITDIV) else $error("divider done unexpected");
endmodule
`default_nettype wire

// ----- tb/sv/masked_tricube_weighted_smoother_core_tb.sv -----
// Self-checking testbench for masked_tricube_weighted_smoother_core.
// Drives sample, weight, query and no-op words with random idling on both channels
// and checks every smoothed value and all_masked flag against a scoreboard predictor.
// Depends on mtws_pkg, mtws_if and the core RTL.
`default_nettype none
module masked_tricube_weighted_smoother_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtws_pkg::*;

    typedef struct {
        logic signed [15:0] value;
        logic               flag;
    } smooth_t;

    class smoother_scoreboard;
        logic [8:0]         reg_width  = 9'd256;
        logic [8:0]         reg_height = 9'd256;
        logic [4:0]         reg_span_x = 5'd16;
        logic [4:0]         reg_span_y = 5'd16;
        logic signed [15:0] reg_mask   = -16'sd32768;
        logic signed [15:0] grid [MAX_GRID_HEIGHT][MAX_GRID_WIDTH];
        logic [14:0]        wtab [MAX_SPAN][MAX_SPAN];
        smooth_t            pending [$];
        int                 errors = 0;

        function int clampi(int v, int hi);
            return (v < 1) ? 1 : (v > hi) ? hi : v;
        endfunction
        function int eff_w();  return clampi(reg_width, MAX_GRID_WIDTH);   endfunction
        function int eff_h();  return clampi(reg_height, MAX_GRID_HEIGHT); endfunction
        function int eff_sx(); return clampi(reg_span_x, MAX_SPAN);        endfunction
        function int eff_sy(); return clampi(reg_span_y, MAX_SPAN);        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
            case (idx)
                REG_GRID_WIDTH:  reg_width  = d[8:0];
                REG_GRID_HEIGHT: reg_height = d[8:0];
                REG_SPAN_X:      reg_span_x = d[4:0];
                REG_SPAN_Y:      reg_span_y = d[4:0];
                REG_MASK_VALUE:  reg_mask   = d;
                default: ;
            endcase
        endfunction

        function smooth_t smooth(int c, int r);
            smooth_t res;
            longint num, den, mag, q;
            int c0, c1, r0, r1, dx, dy;
            num = 0;
            den = 0;
            c0 = c - eff_sx() + 1; c1 = c + eff_sx();
            r0 = r - eff_sy() + 1; r1 = r + eff_sy();
            if (c0 < 0) c0 = 0;
            if (c1 > eff_w()) c1 = eff_w();
            if (r0 < 0) r0 = 0;
            if (r1 > eff_h()) r1 = eff_h();
            for (int j = r0; j < r1; j++) begin
                dy = (j > r) ? j - r : r - j;
                for (int i = c0; i < c1; i++) begin
                    dx = (i > c) ? i - c : c - i;
                    if (grid[j][i] != reg_mask) begin
                        num += longint'(wtab[dy][dx]) * longint'(grid[j][i]);
                        den += longint'(wtab[dy][dx]);
                    end
                end
            end
            if (den == 0) begin
                res.value = reg_mask;
                res.flag  = 1'b1;
            end else begin
                mag = (num < 0) ? -num : num;
                q = (2 * mag + den) / (2 * den);
                if (num < 0) res.value = (q > 32768) ? -16'sd32768 : 16'(-q);
                else         res.value = (q > 32767) ? 16'sd32767 : 16'(q);
                res.flag = 1'b0;
            end
            return res;
        endfunction

        function void note_input(logic [1:0] m, logic [7:0] c, logic [7:0] r,
                                 logic signed [15:0] d);
            case (mode_t'(m))
                MODE_SAMPLE: grid[r][c] = d;
                MODE_WEIGHT:
                    if (c < MAX_SPAN && r < MAX_SPAN)
                        wtab[r][c] = (d < 0) ? 15'd0 : d[14:0];
                MODE_QUERY:  pending = {pending, smooth(c, r)};
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [15:0] v, logic f);
            smooth_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d all_masked=%0b", $time, v, f);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (v !== exp_res.value) begin
                $display("%0t: filtered_value expected %0d actual %0d",
                         $time, exp_res.value, v);
                errors++;
            end
            if (f !== exp_res.flag) begin
                $display("%0t: all_masked expected %0b actual %0b",
                         $time, exp_res.flag, f);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mtws_in_if  in_ch();
    mtws_out_if out_ch();

    masked_tricube_weighted_smoother_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    smoother_scoreboard sb = new();
    bit written [MAX_GRID_HEIGHT][MAX_GRID_WIDTH];
    bit wdone [MAX_SPAN][MAX_SPAN];
    int send_idle = 8;
    int recv_idle = 57;
    int words_sent = 0;

    always #4 clk = ~clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_NONE;
        in_ch.col = '0;
        in_ch.row = '0;
        in_ch.data_value = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.mode, in_ch.col, in_ch.row, in_ch.data_value);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.filtered_value, out_ch.all_masked);
    end

    task automatic send_word(mode_t m, int c, int r, logic [15:0] d);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.col        <= c[7:0];
        in_ch.row        <= r[7:0];
        in_ch.data_value <= d;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (m == MODE_SAMPLE) written[r[7:0]][c[7:0]] = 1'b1;
        if (m == MODE_WEIGHT && c[7:0] < MAX_SPAN && r[7:0] < MAX_SPAN)
            wdone[r[7:0]][c[7:0]] = 1'b1;
        words_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic configure(int gw, int gh, int sx, int sy, logic [15:0] mask);
        wait_drained();
        write_reg(REG_GRID_WIDTH, 16'(gw));
        write_reg(REG_GRID_HEIGHT, 16'(gh));
        write_reg(REG_SPAN_X, 16'(sx));
        write_reg(REG_SPAN_Y, 16'(sy));
        write_reg(REG_MASK_VALUE, mask);
        write_reg(3'd6, 16'($urandom));
        @(posedge clk);
    endtask

    function automatic logic [15:0] sample_value();
        case ($urandom_range(0, 11))
            0, 1: return sb.reg_mask;
            2:    return 16'h7fff;
            3:    return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // fill unwritten cells and weights of the window before asking
    task automatic query_point(int c, int r);
        int c0, c1, r0, r1, dx, dy;
        c0 = c - sb.eff_sx() + 1; c1 = c + sb.eff_sx();
        r0 = r - sb.eff_sy() + 1; r1 = r + sb.eff_sy();
        if (c0 < 0) c0 = 0;
        if (c1 > sb.eff_w()) c1 = sb.eff_w();
        if (r0 < 0) r0 = 0;
        if (r1 > sb.eff_h()) r1 = sb.eff_h();
        for (int j = r0; j < r1; j++)
            for (int i = c0; i < c1; i++) begin
                dy = (j > r) ? j - r : r - j;
                dx = (i > c) ? i - c : c - i;
                if (!wdone[dy][dx])
                    send_word(MODE_WEIGHT, dx, dy, 16'($urandom_range(0, 32767)));
                if (!written[j][i]) send_word(MODE_SAMPLE, i, j, sample_value());
            end
        send_word(MODE_QUERY, c, r, 16'($urandom));
    endtask

    task automatic random_phase(int n);
        int stop, c, r, lim_c, lim_r;
        stop = words_sent + n;
        lim_c = (sb.eff_w() + 3 > 255) ? 255 : sb.eff_w() + 3;
        lim_r = (sb.eff_h() + 3 > 255) ? 255 : sb.eff_h() + 3;
        while (words_sent < stop) begin
            case ($urandom_range(0, 9))
                0: send_word(MODE_WEIGHT, $urandom_range(0, 17), $urandom_range(0, 17),
                             16'($urandom));
                1: send_word(MODE_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255),
                             sample_value());
                2: send_word(MODE_NONE, $urandom, $urandom, 16'($urandom));
                default: begin
                    if (sb.eff_w() * sb.eff_h() > 4096 && $urandom_range(0, 3) != 0) begin
                        c = $urandom_range(0, 40);
                        r = $urandom_range(0, 40);
                    end else begin
                        c = $urandom_range(0, lim_c);
                        r = $urandom_range(0, lim_r);
                    end
                    query_point(c, r);
                end
            endcase
        end
    endtask

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_word(MODE_WEIGHT, 0, 0, 16'h7fff);
        send_word(MODE_WEIGHT, 1, 0, 16'hffff);
        send_word(MODE_WEIGHT, 16, 3, 16'h0100);
        send_word(MODE_WEIGHT, 255, 255, 16'h0100);
        send_word(MODE_NONE, 8'hff, 8'hff, 16'hffff);

        // one-row grid, the other registers at their reset values
        wait_drained();
        write_reg(REG_GRID_HEIGHT, 16'd1);
        query_point(0, 0);
        query_point(255, 0);
        send_word(MODE_SAMPLE, 255, 0, 16'h7fff);
        query_point(255, 0);

        configure(1, 1, 1, 1, 16'h0000);
        send_word(MODE_SAMPLE, 0, 0, 16'h0000);
        query_point(0, 0);
        send_word(MODE_SAMPLE, 0, 0, 16'h8000);
        query_point(0, 0);
        query_point(200, 100);

        configure(0, 0, 0, 0, 16'h7fff);
        query_point(0, 0);
        configure(511, 1, 31, 0, 16'h8000);
        query_point(128, 0);
        configure(1, 511, 0, 31, 16'h8000);
        query_point(0, 128);
        send_word(MODE_WEIGHT, 0, 0, 16'h0000);
        query_point(0, 255);

        configure(20, 12, 3, 5, sample_value());
        random_phase(80);
        send_idle = 57;
        recv_idle = 8;
        configure($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 4),
                  $urandom_range(1, 4), 16'($urandom));
        random_phase(80);
        send_idle = 0;
        recv_idle = 0;
        configure(256, 256, 2, 4, 16'h8000);
        random_phase(40);
        configure(7, 9, 16, 2, sample_value());
        random_phase(40);

        wait_drained();
        repeat (64) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
